[design/assert_macros.svh]
// assertion macros used by the maze builder datapath
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/lewmb_pkg.sv]
// shared codes, defaults and control/status structs of the maze builder
// no dependencies
package lewmb_pkg;

  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int PATH_DEPTH_DEF = 4096;

  localparam logic [6:0] GRID_W_RESET = 7'd16;
  localparam logic [6:0] GRID_H_RESET = 7'd16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_CARVED   = 2'd2;
  localparam logic [1:0] ST_COMPLETE = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       load;
    logic       clr_step;
    logic       root;
    logic       rd_req;
    logic       begin_walk;
    logic       next_calc;
    logic       srch;
    logic       found_apply;
    logic       append;
    logic       carve_init;
    logic       carve_prev;
    logic       carve_cur;
    logic       carve_wr_prev;
    logic       carve_wr_cur;
    logic       carve_end;
    logic       res_valid;
    logic [1:0] res_status;
    logic       res_sides;
  } ctl_t;

  typedef struct packed {
    logic in_range;
    logic walking;
    logic tree_bit;
    logic match;
    logic exhausted;
    logic full;
    logic carve_more;
    logic clr_last;
    logic area_one;
    logic complete;
  } stat_t;

endpackage

[design/lewmb_ctrl.sv]
// controller state machine of the maze builder
// depends on lewmb_pkg
module lewmb_ctrl import lewmb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  stat_t      stat,
  output ctl_t       ctl,
  output logic       busy
);

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_CLR   = 13'b0000000000100,
    S_ROOT  = 13'b0000000001000,
    S_READ  = 13'b0000000010000,
    S_BEGIN = 13'b0000000100000,
    S_NEXT  = 13'b0000001000000,
    S_SRCH  = 13'b0000010000000,
    S_C0    = 13'b0000100000000,
    S_C1    = 13'b0001000000000,
    S_C2    = 13'b0010000000000,
    S_C3    = 13'b0100000000000,
    S_C4    = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.res_status = ST_OK;
    case (state)
      S_INIT: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (command)
            CMD_CLEAR: begin
              if (stat.in_range) state_next = S_CLR;
              else begin
                ctl.res_valid  = 1'b1;
                ctl.res_status = ST_REJECT;
              end
            end
            CMD_BEGIN: begin
              if (stat.in_range && !stat.walking) begin
                ctl.rd_req = 1'b1;
                state_next = S_BEGIN;
              end else begin
                ctl.res_valid  = 1'b1;
                ctl.res_status = ST_REJECT;
              end
            end
            CMD_STEP: begin
              if (stat.walking) state_next = S_NEXT;
              else begin
                ctl.res_valid  = 1'b1;
                ctl.res_status = ST_REJECT;
              end
            end
            default: begin
              if (stat.in_range) begin
                ctl.rd_req = 1'b1;
                state_next = S_READ;
              end else begin
                ctl.res_valid  = 1'b1;
                ctl.res_status = ST_REJECT;
              end
            end
          endcase
        end
      end
      S_CLR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_ROOT;
      end
      S_ROOT: begin
        ctl.root       = 1'b1;
        ctl.res_valid  = 1'b1;
        ctl.res_status = stat.area_one ? ST_COMPLETE : ST_OK;
        state_next     = S_IDLE;
      end
      S_READ: begin
        ctl.res_valid = 1'b1;
        ctl.res_sides = 1'b1;
        state_next    = S_IDLE;
      end
      S_BEGIN: begin
        ctl.res_valid = 1'b1;
        if (stat.tree_bit) ctl.res_status = ST_REJECT;
        else ctl.begin_walk = 1'b1;
        state_next = S_IDLE;
      end
      S_NEXT: begin
        ctl.next_calc = 1'b1;
        state_next    = S_SRCH;
      end
      S_SRCH: begin
        ctl.srch = 1'b1;
        if (stat.match) begin
          ctl.found_apply = 1'b1;
          ctl.res_valid   = 1'b1;
          state_next      = S_IDLE;
        end else if (stat.exhausted) begin
          if (stat.full) begin
            ctl.res_valid  = 1'b1;
            ctl.res_status = ST_REJECT;
            state_next     = S_IDLE;
          end else if (stat.tree_bit) begin
            ctl.append = 1'b1;
            state_next = S_C0;
          end else begin
            ctl.append    = 1'b1;
            ctl.res_valid = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      S_C0: begin
        ctl.carve_init = 1'b1;
        state_next     = S_C1;
      end
      S_C1: begin
        ctl.carve_prev = 1'b1;
        state_next     = S_C2;
      end
      S_C2: begin
        ctl.carve_cur = 1'b1;
        state_next    = S_C3;
      end
      S_C3: begin
        ctl.carve_wr_prev = 1'b1;
        state_next        = S_C4;
      end
      S_C4: begin
        ctl.carve_wr_cur = 1'b1;
        if (stat.carve_more) state_next = S_C2;
        else begin
          ctl.carve_end  = 1'b1;
          ctl.res_valid  = 1'b1;
          ctl.res_status = stat.complete ? ST_COMPLETE : ST_CARVED;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

[design/lewmb_datapath.sv]
// datapath of the maze builder: config, cell and path memories, walk registers
// depends on lewmb_pkg and assert_macros.svh
`include "assert_macros.svh"
module lewmb_datapath import lewmb_pkg::*; #(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  input  logic [5:0] row,
  input  logic [5:0] col,
  input  logic [1:0] direction,
  input  ctl_t       ctl,
  output stat_t      stat,
  output logic       done,
  output logic [1:0] status,
  output logic [3:0] open_sides,
  output logic       walk_active
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int CELLS = 1 << AW;
  localparam int PW    = $clog2(PATH_DEPTH);
  localparam int LW    = $clog2(PATH_DEPTH + 1);
  localparam int WW    = $clog2(MAX_COLS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int TW    = AW + 1;

  logic [6:0]    grid_width, grid_height;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  logic [4:0]    cell_mem [CELLS];
  logic [AW-1:0] path_mem [PATH_DEPTH];
  logic [4:0]    cm_q;
  logic [AW-1:0] pm_q;

  logic [RW-1:0] req_r;
  logic [CW-1:0] req_c;
  logic [1:0]    req_dir;
  logic [AW-1:0] cur_cell, next_cell, prev_cell, cv_cell, clr_addr;
  logic [LW-1:0] len, idx, pidx, ci;
  logic          walking, walking_next, pv;
  logic [TW-1:0] tree_count;

  logic          cm_we, cm_re, pm_we, pm_re;
  logic [AW-1:0] cm_waddr, cm_raddr, pm_wdata;
  logic [4:0]    cm_wdata;
  logic [PW-1:0] pm_waddr, pm_raddr;

  logic [RW:0]   cr;
  logic [CW:0]   cc;
  logic [RW-1:0] cur_r, nr, pr_r, cv_r;
  logic [CW-1:0] cur_c, nc, pr_c, cv_c;
  logic [3:0]    m_prev, m_cur;
  logic          in_grid;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_W_RESET;
      grid_height <= GRID_H_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_WIDTH) grid_width <= cfg_data;
      else grid_height <= cfg_data;
    end
  end

  always_comb begin
    if (grid_width == 7'd0) eff_w = WW'(1);
    else if (32'(grid_width) > MAX_COLS) eff_w = WW'(MAX_COLS);
    else eff_w = WW'(grid_width);
    if (grid_height == 7'd0) eff_h = HW'(1);
    else if (32'(grid_height) > MAX_ROWS) eff_h = HW'(MAX_ROWS);
    else eff_h = HW'(grid_height);
  end

  assign wm1 = CW'(eff_w - WW'(1));
  assign hm1 = RW'(eff_h - HW'(1));

  // step target, clamped on both axes
  assign cur_r = cur_cell[AW-1:CW];
  assign cur_c = cur_cell[CW-1:0];
  always_comb begin
    case (req_dir)
      DIR_UP:   cr = (cur_r == '0) ? '0 : {1'b0, cur_r} - (RW+1)'(1);
      DIR_DOWN: cr = {1'b0, cur_r} + (RW+1)'(1);
      default:  cr = {1'b0, cur_r};
    endcase
    case (req_dir)
      DIR_LEFT:  cc = (cur_c == '0) ? '0 : {1'b0, cur_c} - (CW+1)'(1);
      DIR_RIGHT: cc = {1'b0, cur_c} + (CW+1)'(1);
      default:   cc = {1'b0, cur_c};
    endcase
    nr = (cr > {1'b0, hm1}) ? hm1 : cr[RW-1:0];
    nc = (cc > {1'b0, wm1}) ? wm1 : cc[CW-1:0];
  end

  // passage bits for one carved pair
  assign pr_r = prev_cell[AW-1:CW];
  assign pr_c = prev_cell[CW-1:0];
  assign cv_r = cv_cell[AW-1:CW];
  assign cv_c = cv_cell[CW-1:0];
  assign in_grid = (32'(pr_r) < 32'(eff_h)) && (32'(cv_r) < 32'(eff_h)) &&
                   (32'(pr_c) < 32'(eff_w)) && (32'(cv_c) < 32'(eff_w));
  always_comb begin
    m_prev = 4'd0;
    m_cur  = 4'd0;
    if (in_grid) begin
      if ({1'b0, pr_r} == {1'b0, cv_r} + (RW+1)'(1) && pr_c == cv_c) begin
        m_prev = 4'b0001;
        m_cur  = 4'b0010;
      end else if ({1'b0, cv_r} == {1'b0, pr_r} + (RW+1)'(1) && pr_c == cv_c) begin
        m_prev = 4'b0010;
        m_cur  = 4'b0001;
      end else if (pr_r == cv_r && {1'b0, pr_c} == {1'b0, cv_c} + (CW+1)'(1)) begin
        m_prev = 4'b0100;
        m_cur  = 4'b1000;
      end else if (pr_r == cv_r && {1'b0, cv_c} == {1'b0, pr_c} + (CW+1)'(1)) begin
        m_prev = 4'b1000;
        m_cur  = 4'b0100;
      end
    end
  end

  assign stat.in_range   = (32'(row) < 32'(eff_h)) && (32'(col) < 32'(eff_w));
  assign stat.walking    = walking;
  assign stat.tree_bit   = cm_q[4];
  assign stat.match      = pv && (pm_q == next_cell);
  assign stat.exhausted  = (idx == len) && !pv;
  assign stat.full       = (32'(len) == PATH_DEPTH);
  assign stat.carve_more = (ci < len);
  assign stat.clr_last   = (clr_addr == {AW{1'b1}});
  assign stat.area_one   = (eff_h == HW'(1)) && (eff_w == WW'(1));
  assign stat.complete   = 32'(tree_count) >= 32'(eff_h) * 32'(eff_w);

  // memory port selection
  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = clr_addr;
    cm_wdata = 5'd0;
    if (ctl.root) begin
      cm_we    = 1'b1;
      cm_waddr = {req_r, req_c};
      cm_wdata = 5'b10000;
    end else if (ctl.carve_wr_prev) begin
      cm_we    = 1'b1;
      cm_waddr = prev_cell;
      cm_wdata = {1'b1, cm_q[3:0] | m_prev};
    end else if (ctl.carve_wr_cur) begin
      cm_we    = 1'b1;
      cm_waddr = cv_cell;
      cm_wdata = {cm_q[4], cm_q[3:0] | m_cur};
    end else if (ctl.clr_step) begin
      cm_we    = 1'b1;
    end
    cm_re    = ctl.rd_req || ctl.srch || ctl.carve_cur || ctl.carve_wr_prev;
    if (ctl.rd_req) cm_raddr = {RW'(row), CW'(col)};
    else if (ctl.srch) cm_raddr = next_cell;
    else if (ctl.carve_cur) cm_raddr = prev_cell;
    else cm_raddr = cv_cell;

    pm_we    = ctl.begin_walk || ctl.append;
    pm_waddr = ctl.append ? len[PW-1:0] : '0;
    pm_wdata = ctl.append ? next_cell : {req_r, req_c};
    pm_re    = (ctl.srch && (idx < len)) || ctl.carve_init || ctl.carve_prev ||
               (ctl.carve_wr_cur && (ci < len));
    if (ctl.srch) pm_raddr = idx[PW-1:0];
    else if (ctl.carve_init) pm_raddr = '0;
    else pm_raddr = ci[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
    if (cm_re) cm_q <= cell_mem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (pm_we) path_mem[pm_waddr] <= pm_wdata;
    if (pm_re) pm_q <= path_mem[pm_raddr];
  end

  always_comb begin
    walking_next = walking;
    if (ctl.root || ctl.carve_end) walking_next = 1'b0;
    else if (ctl.begin_walk) walking_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking    <= 1'b0;
      len        <= '0;
      cur_cell   <= '0;
      tree_count <= '0;
      clr_addr   <= '0;
      pv         <= 1'b0;
      done       <= 1'b0;
    end else begin
      walking <= walking_next;
      done    <= ctl.res_valid;
      if (ctl.clr_step) clr_addr <= clr_addr + AW'(1);
      if (ctl.root) begin
        len        <= '0;
        tree_count <= TW'(1);
      end else if (ctl.carve_wr_prev && !cm_q[4]) begin
        tree_count <= tree_count + TW'(1);
      end
      if (ctl.begin_walk) begin
        len      <= LW'(1);
        cur_cell <= {req_r, req_c};
      end else if (ctl.found_apply) begin
        len      <= pidx + LW'(1);
        cur_cell <= next_cell;
      end else if (ctl.append) begin
        len      <= len + LW'(1);
        cur_cell <= next_cell;
      end else if (ctl.carve_end) begin
        len      <= '0;
      end
      if (ctl.next_calc) pv <= 1'b0;
      else if (ctl.srch) pv <= (idx < len);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r   <= RW'(row);
      req_c   <= CW'(col);
      req_dir <= direction;
    end
    if (ctl.next_calc) begin
      next_cell <= {nr, nc};
      idx       <= '0;
    end else if (ctl.srch && (idx < len)) begin
      idx  <= idx + LW'(1);
      pidx <= idx;
    end
    if (ctl.carve_init) ci <= LW'(1);
    else if (ctl.carve_prev || (ctl.carve_wr_cur && (ci < len))) ci <= ci + LW'(1);
    if (ctl.carve_prev) prev_cell <= pm_q;
    else if (ctl.carve_wr_cur) prev_cell <= cv_cell;
    if (ctl.carve_cur) cv_cell <= pm_q;
    if (ctl.res_valid) begin
      status      <= ctl.res_status;
      open_sides  <= ctl.res_sides ? cm_q[3:0] : 4'd0;
      walk_active <= walking_next;
    end
  end

  `ASSERT_ALWAYS(a_len_bound, clk, rst, 32'(len) <= PATH_DEPTH)
  `ASSERT_ALWAYS(a_walk_len, clk, rst, !walking || (len != '0))
  `ASSERT_NEXT(a_result_strobe, clk, rst, ctl.res_valid, done)
  `ASSERT_ALWAYS(a_count_bound, clk, rst, 32'(tree_count) <= CELLS)

endmodule

[design/loop_erased_walk_maze_builder.sv]
// top level of the loop-erased random walk maze builder
// depends on lewmb_pkg, lewmb_ctrl and lewmb_datapath
//
// One request is taken when start is high and busy is low; its single result
// shows on status, open_sides and walk_active, which hold it, while done is
// high for exactly one cycle; it must be caught then, as the receiver cannot
// stall it. After reset every address of the cell memory is swept clear while
// busy is high; a clear request repeats that sweep before its result. Read and
// begin give their result after a read of the cell memory, a rejected request
// straight from the idle state. A step walks the stored path one entry a cycle;
// a step that reaches the tree then carves the path, through S_C2, S_C3 and
// S_C4 for each path cell, over the cell memory's read and write ports.
module loop_erased_walk_maze_builder import lewmb_pkg::*; #(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [5:0] row,
  input  logic [5:0] col,
  input  logic [1:0] direction,
  output logic       done,
  output logic [1:0] status,
  output logic [3:0] open_sides,
  output logic       walk_active,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  lewmb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  lewmb_datapath #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PATH_DEPTH (PATH_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .row         (row),
    .col         (col),
    .direction   (direction),
    .ctl         (ctl),
    .stat        (stat),
    .done        (done),
    .status      (status),
    .open_sides  (open_sides),
    .walk_active (walk_active)
  );

endmodule
